/* hdl/assert_macros.svh */
// Assertion macros used by the checker file rtex_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

/* hdl/rtex_pkg.sv */
// Types and constants of the R-type execute unit.
// No dependencies.
package rtex_pkg;
  localparam int unsigned XLEN = 32;
  localparam int unsigned RIDX = 5;
  localparam logic [RIDX-1:0] LINK_REG = 5'd31;

  typedef enum logic [5:0] {
    F_SLL = 6'd0, F_SRL = 6'd2, F_SRA = 6'd3, F_SLLV = 6'd4, F_SRLV = 6'd6,
    F_SRAV = 6'd7, F_JR = 6'd8, F_JALR = 6'd9, F_MFHI = 6'd16, F_MFLO = 6'd18,
    F_MULT = 6'd24, F_MULTU = 6'd25, F_DIV = 6'd26, F_DIVU = 6'd27,
    F_ADD = 6'd32, F_ADDU = 6'd33, F_SUB = 6'd34, F_SUBU = 6'd35,
    F_AND = 6'd36, F_OR = 6'd37, F_XOR = 6'd38, F_NOR = 6'd39,
    F_SLT = 6'd42, F_SLTU = 6'd43
  } func_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_DONE
  } state_t;

  typedef struct packed {
    logic          we;
    logic [RIDX-1:0] idx;
    logic [XLEN-1:0] val;
    logic          jmp;
    logic [XLEN-1:0] tgt;
    logic [XLEN-1:0] hi;
    logic [XLEN-1:0] lo;
    logic          unk;
  } result_t;

  // Division unit control.
  typedef struct packed {
    logic          start;
    logic          sgn;
    logic [XLEN-1:0] a;
    logic [XLEN-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [XLEN-1:0] q;
    logic [XLEN-1:0] r;
  } div_rsp_t;
endpackage

/* hdl/rtex_if.sv */
// Valid/ready channel interfaces for the execute unit.
// Depends on rtex_pkg.
interface rtex_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] func;
  logic [4:0] src_a;
  logic [4:0] src_b;
  logic [4:0] dest;
  logic [4:0] shift_amount;
  logic [31:0] current_pc;
  modport source (output valid, func, src_a, src_b, dest, shift_amount, current_pc,
                  input ready);
  modport sink (input valid, func, src_a, src_b, dest, shift_amount, current_pc,
                output ready);
endinterface

interface rtex_out_if;
  logic valid;
  logic ready;
  rtex_pkg::result_t res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface

/* hdl/rtex_ram.sv */
// Generic single-write, single-read RAM with registered read.
// No dependencies.
module rtex_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hdl/rtex_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rtex_pkg.
module rtex_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rtex_pkg::div_req_t req,
  output rtex_pkg::div_rsp_t rsp
);
  localparam int unsigned W = rtex_pkg::XLEN;
  logic [W-1:0] q_r, r_r, d_r;
  logic [$clog2(W):0] cnt_r;
  logic busy_r, fin_r, negq_r, negr_r;
  logic [W:0] trial;

  assign trial = {r_r, q_r[W-1]} - {1'b0, d_r};

  // Magnitudes loaded at start, one bit shifted in per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        r_r    <= '0;
        q_r    <= (req.sgn && req.a[W-1]) ? -req.a : req.a;
        d_r    <= (req.sgn && req.b[W-1]) ? -req.b : req.b;
        negq_r <= req.sgn && (req.a[W-1] ^ req.b[W-1]);
        negr_r <= req.sgn && req.a[W-1];
      end else if (busy_r) begin
        if (trial[W]) begin
          r_r <= {r_r[W-2:0], q_r[W-1]};
          q_r <= {q_r[W-2:0], 1'b0};
        end else begin
          r_r <= trial[W-1:0];
          q_r <= {q_r[W-2:0], 1'b1};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(W)+1)'(W-1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = fin_r;
  assign rsp.q = negq_r ? -q_r : q_r;
  assign rsp.r = negr_r ? -r_r : r_r;
endmodule

/* hdl/r_type_instruction_execute_unit.sv */
// R-type execute unit top level: register file RAMs, sequencer, ALU, mul/div.
// Depends on rtex_pkg, rtex_if, rtex_ram, rtex_div.
//
//   channel | dir | handshake       | payload
//   in      | in  | valid/ready     | func, src_a, src_b, dest, shift_amount, current_pc
//   out     | out | valid/ready     | result_t (write, jump, hi/lo, unknown_op)
//
// After reset, a clearing pass over all 32 entries zeroes the register file; no input is taken.
// Each instruction: accept (S_IDLE), RAM read (S_READ) and execute (S_EXEC), then the result
// waits in the output register (S_DONE); mult/multu add S_MUL (registered 32x32 product).
// div/divu with a nonzero divisor add S_DIV, which waits for the radix-2 divider.
// A stalled output holds the block; the next transfer is taken once the result leaves.
module r_type_instruction_execute_unit (
  input logic clk,
  input logic rst_n,
  rtex_in_if.sink    in_ch,
  rtex_out_if.source out_ch
);
  localparam int unsigned W = rtex_pkg::XLEN;
  localparam int unsigned RI = rtex_pkg::RIDX;

  rtex_pkg::state_t state_r, state_nxt;
  logic [5:0]    func_r;
  logic [RI-1:0] ra_r, rb_r, rd_r, sh_r, clr_r;
  logic [W-1:0]  pc_r, hi_r, lo_r;
  logic [W-1:0]  a, b;
  logic [2*W-1:0] prod_r;
  logic [W:0]    mul_a, mul_b;
  logic [2*W-1:0] prod_full;
  rtex_pkg::result_t res_r, res_nxt;
  logic we_ram;
  logic [RI-1:0] waddr;
  logic [W-1:0] wdata;
  logic [4:0] amt;
  logic [W-1:0] wv;
  logic wr, jmp, unk;
  logic [RI-1:0] widx;
  rtex_pkg::div_req_t dreq;
  rtex_pkg::div_rsp_t drsp;
  logic [W-1:0] hi_n, lo_n;

  // Two copies of the register file give the two read ports.
  rtex_ram #(.WIDTH(W), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(we_ram), .waddr(waddr), .wdata(wdata), .raddr(ra_r), .rdata(a));
  rtex_ram #(.WIDTH(W), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(we_ram), .waddr(waddr), .wdata(wdata), .raddr(rb_r), .rdata(b));

  rtex_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign dreq.start = (state_r == rtex_pkg::S_EXEC) &&
                      (func_r == rtex_pkg::F_DIV || func_r == rtex_pkg::F_DIVU) && b != '0;
  assign dreq.sgn = (func_r == rtex_pkg::F_DIV);
  assign dreq.a = a;
  assign dreq.b = b;

  // Multiplier operands: sign bit extended only for mult.
  assign mul_a = {(func_r == rtex_pkg::F_MULT) & a[W-1], a};
  assign mul_b = {(func_r == rtex_pkg::F_MULT) & b[W-1], b};
  assign prod_full = (2*W)'($signed(mul_a)) * (2*W)'($signed(mul_b));

  // Execute decode (one ALU op, one shifter).
  always_comb begin
    wr = 1'b1; jmp = 1'b0; unk = 1'b0; widx = rd_r; wv = '0;
    amt = (func_r[2]) ? a[4:0] : sh_r;
    case (func_r)
      rtex_pkg::F_SLL, rtex_pkg::F_SLLV: wv = b << amt;
      rtex_pkg::F_SRL, rtex_pkg::F_SRLV: wv = b >> amt;
      rtex_pkg::F_SRA, rtex_pkg::F_SRAV: wv = W'($signed(b) >>> amt);
      rtex_pkg::F_JR: begin wr = 1'b0; jmp = 1'b1; end
      rtex_pkg::F_JALR: begin jmp = 1'b1; widx = rtex_pkg::LINK_REG; wv = pc_r + 32'd4; end
      rtex_pkg::F_MFHI: wv = hi_r;
      rtex_pkg::F_MFLO: wv = lo_r;
      rtex_pkg::F_MULT, rtex_pkg::F_MULTU, rtex_pkg::F_DIV, rtex_pkg::F_DIVU: wr = 1'b0;
      rtex_pkg::F_ADD, rtex_pkg::F_ADDU: wv = a + b;
      rtex_pkg::F_SUB, rtex_pkg::F_SUBU: wv = a - b;
      rtex_pkg::F_AND: wv = a & b;
      rtex_pkg::F_OR:  wv = a | b;
      rtex_pkg::F_XOR: wv = a ^ b;
      rtex_pkg::F_NOR: wv = ~(a | b);
      rtex_pkg::F_SLT: wv = {31'd0, $signed(a) < $signed(b)};
      rtex_pkg::F_SLTU: wv = {31'd0, a < b};
      default: begin wr = 1'b0; unk = 1'b1; end
    endcase
    if (widx == '0) wr = 1'b0;
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    hi_n = hi_r; lo_n = lo_r;
    we_ram = 1'b0; waddr = clr_r; wdata = '0;
    case (state_r)
      rtex_pkg::S_CLEAR: begin
        we_ram = 1'b1;
        if (clr_r == '1) state_nxt = rtex_pkg::S_IDLE;
      end
      rtex_pkg::S_IDLE: if (in_ch.valid) state_nxt = rtex_pkg::S_READ;
      rtex_pkg::S_READ: state_nxt = rtex_pkg::S_EXEC;
      rtex_pkg::S_EXEC: begin
        res_nxt.we  = wr;
        res_nxt.idx = wr ? widx : '0;
        res_nxt.val = wr ? wv : '0;
        res_nxt.jmp = jmp;
        res_nxt.tgt = jmp ? a : '0;
        res_nxt.unk = unk;
        res_nxt.hi = hi_r;
        res_nxt.lo = lo_r;
        we_ram = wr; waddr = widx; wdata = wv;
        if (func_r == rtex_pkg::F_MULT || func_r == rtex_pkg::F_MULTU)
          state_nxt = rtex_pkg::S_MUL;
        else if (dreq.start) state_nxt = rtex_pkg::S_DIV;
        else state_nxt = rtex_pkg::S_DONE;
      end
      rtex_pkg::S_MUL: begin
        hi_n = prod_r[2*W-1:W]; lo_n = prod_r[W-1:0];
        res_nxt.hi = hi_n; res_nxt.lo = lo_n;
        state_nxt = rtex_pkg::S_DONE;
      end
      rtex_pkg::S_DIV: if (drsp.done) begin
        hi_n = drsp.r; lo_n = drsp.q;
        res_nxt.hi = hi_n; res_nxt.lo = lo_n;
        state_nxt = rtex_pkg::S_DONE;
      end
      rtex_pkg::S_DONE: if (out_ch.ready) state_nxt = rtex_pkg::S_IDLE;
      default: state_nxt = rtex_pkg::S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtex_pkg::S_CLEAR;
      clr_r <= '0;
      hi_r <= '0;
      lo_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == rtex_pkg::S_CLEAR) clr_r <= clr_r + 1'b1;
      hi_r <= hi_n;
      lo_r <= lo_n;
    end
  end

  // Payload registers: instruction fields, product, result.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func; ra_r <= in_ch.src_a; rb_r <= in_ch.src_b;
      rd_r <= in_ch.dest; sh_r <= in_ch.shift_amount; pc_r <= in_ch.current_pc;
    end
    prod_r <= prod_full;
    res_r <= res_nxt;
  end

  assign in_ch.ready = (state_r == rtex_pkg::S_IDLE);
  assign out_ch.valid = (state_r == rtex_pkg::S_DONE);
  assign out_ch.res = res_r;
endmodule

/* hdl/rtex_checker.sv */
// Port-level checks for the execute unit, bound to the top level.
// Depends on rtex_pkg, rtex_if, assert_macros.svh.
`include "assert_macros.svh"
module rtex_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input rtex_pkg::result_t res
);
  `CHK_IMPLY(a_no_overlap, clk, rst_n, out_valid, !in_ready)
  `CHK_IMPLY(a_zero_dest, clk, rst_n, out_valid && res.we, res.idx != '0)
  `CHK_IMPLY(a_unk_quiet, clk, rst_n, out_valid && res.unk, !res.we && !res.jmp)
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res))
  // One instruction in flight: no input transfer right after one
  `CHK_NEXT(a_one_accept, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind r_type_instruction_execute_unit rtex_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .res(out_ch.res));

/* dv/tb_r_type_instruction_execute_unit.sv */
// Self-checking testbench for the R-type execute unit: a scoreboard class predicts
// each result from its own register file and HI/LO copy. Depends on rtex_pkg and rtex_if.
module tb_r_type_instruction_execute_unit;

  // Prediction and checking of execute results
  class exec_scoreboard;
    logic [31:0] gpr [32];
    logic [31:0] hi_q, lo_q;
    rtex_pkg::result_t pending [$];
    int          errors;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      hi_q = '0;
      lo_q = '0;
      errors = 0;
    endfunction

    // Execute one instruction on the shadow state and queue its result.
    function void note_instr(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                             logic [4:0] rd, logic [4:0] sh, logic [31:0] pc);
      logic [31:0] a, b, ma, mb, q, r;
      logic [63:0] prod;
      rtex_pkg::result_t e;
      logic        wr;
      a = gpr[rs];
      b = gpr[rt];
      e = '0;
      wr = 1'b0;
      e.idx = rd;
      case (fn)
        rtex_pkg::F_SLL:  begin wr = 1'b1; e.val = b << sh; end
        rtex_pkg::F_SRL:  begin wr = 1'b1; e.val = b >> sh; end
        rtex_pkg::F_SRA:  begin wr = 1'b1; e.val = $signed(b) >>> sh; end
        rtex_pkg::F_SLLV: begin wr = 1'b1; e.val = b << a[4:0]; end
        rtex_pkg::F_SRLV: begin wr = 1'b1; e.val = b >> a[4:0]; end
        rtex_pkg::F_SRAV: begin wr = 1'b1; e.val = $signed(b) >>> a[4:0]; end
        rtex_pkg::F_JR:   begin e.jmp = 1'b1; e.tgt = a; end
        rtex_pkg::F_JALR: begin
          e.jmp = 1'b1;
          e.tgt = a;
          wr = 1'b1;
          e.idx = rtex_pkg::LINK_REG;
          e.val = pc + 32'd4;
        end
        rtex_pkg::F_MFHI: begin wr = 1'b1; e.val = hi_q; end
        rtex_pkg::F_MFLO: begin wr = 1'b1; e.val = lo_q; end
        rtex_pkg::F_MULT: begin
          prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
          hi_q = prod[63:32];
          lo_q = prod[31:0];
        end
        rtex_pkg::F_MULTU: begin
          prod = {32'd0, a} * {32'd0, b};
          hi_q = prod[63:32];
          lo_q = prod[31:0];
        end
        rtex_pkg::F_DIV: begin
          // magnitude divide, then fix signs; zero divisor leaves HI/LO alone
          if (b != 0) begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r = ma % mb;
            lo_q = (a[31] != b[31]) ? -q : q;
            hi_q = a[31] ? -r : r;
          end
        end
        rtex_pkg::F_DIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
        rtex_pkg::F_ADD, rtex_pkg::F_ADDU: begin wr = 1'b1; e.val = a + b; end
        rtex_pkg::F_SUB, rtex_pkg::F_SUBU: begin wr = 1'b1; e.val = a - b; end
        rtex_pkg::F_AND:  begin wr = 1'b1; e.val = a & b; end
        rtex_pkg::F_OR:   begin wr = 1'b1; e.val = a | b; end
        rtex_pkg::F_XOR:  begin wr = 1'b1; e.val = a ^ b; end
        rtex_pkg::F_NOR:  begin wr = 1'b1; e.val = ~(a | b); end
        rtex_pkg::F_SLT: begin
          wr = 1'b1;
          e.val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        end
        rtex_pkg::F_SLTU: begin wr = 1'b1; e.val = (a < b) ? 32'd1 : 32'd0; end
        default: e.unk = 1'b1;
      endcase
      if (wr && e.idx == 0) wr = 1'b0;
      if (wr) gpr[e.idx] = e.val;
      else begin
        e.idx = '0;
        e.val = '0;
      end
      e.we = wr;
      e.hi = hi_q;
      e.lo = lo_q;
      pending.push_back(e);
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_result(rtex_pkg::result_t got);
      rtex_pkg::result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.we !== e.we) report_field("write_enable", e.we, got.we);
      if (got.idx !== e.idx) report_field("write_index", e.idx, got.idx);
      if (got.val !== e.val) report_field("write_value", e.val, got.val);
      if (got.jmp !== e.jmp) report_field("jump_taken", e.jmp, got.jmp);
      if (got.tgt !== e.tgt) report_field("jump_target", e.tgt, got.tgt);
      if (got.hi !== e.hi) report_field("hi_value", e.hi, got.hi);
      if (got.lo !== e.lo) report_field("lo_value", e.lo, got.lo);
      if (got.unk !== e.unk) report_field("unknown_op", e.unk, got.unk);
    endfunction

    function void report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    endfunction
  endclass

  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  rtex_in_if  in_ch();
  rtex_out_if out_ch();
  exec_scoreboard sb;
  int  cycles = 0;
  bit  quiet_sink = 1'b0;   // no random stalls on the result side
  bit  quiet_src = 1'b0;    // no random gaps on the instruction side
  bit  hold_sink = 1'b0;    // long receiver hold-off

  r_type_instruction_execute_unit u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                                         .out_ch(out_ch));

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 0;
    in_ch.func = '0;
    in_ch.src_a = '0;
    in_ch.src_b = '0;
    in_ch.dest = '0;
    in_ch.shift_amount = '0;
    in_ch.current_pc = '0;
    out_ch.ready = 0;
  end

  // Result side: sample at the rising edge, change ready at the falling edge
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.res);
  end

  always @(negedge clk) begin
    if (!rst_n || hold_sink) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 38);
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_r_type_instruction_execute_unit NOT OK");
      $finish;
    end
  end

  // Offer one instruction and hold it until it is taken.
  task automatic send_instr(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                            logic [4:0] rd, logic [4:0] sh, logic [31:0] pc);
    while (!quiet_src && $urandom_range(99) < 38) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.src_a <= rs;
    in_ch.src_b <= rt;
    in_ch.dest <= rd;
    in_ch.shift_amount <= sh;
    in_ch.current_pc <= pc;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_instr(fn, rs, rt, rd, sh, pc);
    @(negedge clk);
  endtask

  function automatic logic [5:0] pick_func();
    rtex_pkg::func_t ops [] = '{
      rtex_pkg::F_SLL, rtex_pkg::F_SRL, rtex_pkg::F_SRA, rtex_pkg::F_SLLV,
      rtex_pkg::F_SRLV, rtex_pkg::F_SRAV, rtex_pkg::F_JR, rtex_pkg::F_JALR,
      rtex_pkg::F_MFHI, rtex_pkg::F_MFLO, rtex_pkg::F_MULT, rtex_pkg::F_MULTU,
      rtex_pkg::F_DIV, rtex_pkg::F_DIVU, rtex_pkg::F_ADD, rtex_pkg::F_ADDU,
      rtex_pkg::F_SUB, rtex_pkg::F_SUBU, rtex_pkg::F_AND, rtex_pkg::F_OR,
      rtex_pkg::F_XOR, rtex_pkg::F_NOR, rtex_pkg::F_SLT, rtex_pkg::F_SLTU};
    if ($urandom_range(99) < 6) return 6'($urandom_range(63));
    return ops[$urandom_range(ops.size() - 1)];
  endfunction

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [4:0] r1, r2;
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: seed registers with extremes via nor/sub/sll, then corner cases of most operations
    quiet_src = 1'b1;
    send_instr(rtex_pkg::F_NOR, 5'd0, 5'd0, 5'd1, 5'd0, 32'h0);   // r1 = all ones
    send_instr(rtex_pkg::F_SUB, 5'd0, 5'd1, 5'd2, 5'd0, 32'h0);   // r2 = 1
    send_instr(rtex_pkg::F_SLL, 5'd0, 5'd2, 5'd3, 5'd31, 32'h0);  // r3 = 0x80000000
    send_instr(rtex_pkg::F_SRA, 5'd0, 5'd3, 5'd4, 5'd0, 32'h0);   // sra by zero
    send_instr(rtex_pkg::F_SRAV, 5'd1, 5'd3, 5'd5, 5'd0, 32'h0);  // srav by 31, negative
    send_instr(rtex_pkg::F_DIV, 5'd3, 5'd1, 5'd0, 5'd0, 32'h0);   // -2^31 / -1 overflow
    send_instr(rtex_pkg::F_MFLO, 5'd0, 5'd0, 5'd6, 5'd0, 32'h0);
    send_instr(rtex_pkg::F_DIVU, 5'd1, 5'd0, 5'd0, 5'd0, 32'h0);  // divide by zero
    send_instr(rtex_pkg::F_DIV, 5'd3, 5'd0, 5'd0, 5'd0, 32'h0);
    send_instr(rtex_pkg::F_MULT, 5'd1, 5'd3, 5'd0, 5'd0, 32'h0);
    send_instr(rtex_pkg::F_MULTU, 5'd1, 5'd1, 5'd0, 5'd0, 32'h0);
    send_instr(rtex_pkg::F_MFHI, 5'd0, 5'd0, 5'd7, 5'd0, 32'h0);
    send_instr(rtex_pkg::F_JALR, 5'd1, 5'd0, 5'd0, 5'd0, 32'hFFFF_FFFC); // link wraps
    send_instr(rtex_pkg::F_JALR, 5'd31, 5'd0, 5'd0, 5'd0, 32'h1000); // rs before link
    send_instr(rtex_pkg::F_JR, 5'd3, 5'd0, 5'd0, 5'd0, 32'h0);
    send_instr(rtex_pkg::F_ADD, 5'd3, 5'd3, 5'd8, 5'd0, 32'h0);   // overflow wraps
    send_instr(rtex_pkg::F_SLT, 5'd3, 5'd2, 5'd9, 5'd0, 32'h0);
    send_instr(rtex_pkg::F_SLTU, 5'd3, 5'd2, 5'd10, 5'd0, 32'h0);
    send_instr(rtex_pkg::F_ADDU, 5'd1, 5'd2, 5'd0, 5'd0, 32'h0);  // destination zero
    send_instr(6'd63, 5'd1, 5'd1, 5'd11, 5'd31, 32'hFFFF_FFFF);   // unknown code
    send_instr(rtex_pkg::F_SRLV, 5'd1, 5'd1, 5'd12, 5'd0, 32'h0);
    send_instr(rtex_pkg::F_SRL, 5'd0, 5'd1, 5'd13, 5'd31, 32'h0);

    // Sender pauses until every result is back
    wait_drained();
    quiet_src = 1'b0;

    // Random instructions; a long idle-free stretch and a long sink hold-off
    for (int n = 0; n < 950; n++) begin
      if (n == 300) begin
        quiet_src = 1'b1;
        quiet_sink = 1'b1;
      end
      if (n == 420) begin
        quiet_src = 1'b0;
        quiet_sink = 1'b0;
      end
      if (n == 600) begin
        fork
          begin
            hold_sink = 1'b1;
            repeat (200) @(negedge clk);
            hold_sink = 1'b0;
          end
        join_none
      end
      r1 = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom_range(31));
      r2 = 5'($urandom_range(31));
      send_instr(pick_func(), r1, r2, 5'($urandom_range(31)), 5'($urandom_range(31)),
                 $urandom());
    end

    wait_drained();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_r_type_instruction_execute_unit OK");
    else
      $display("tb_r_type_instruction_execute_unit NOT OK");
    $finish;
  end
endmodule

/* r_type_instruction_execute_unit.f */
+incdir+hdl
hdl/rtex_pkg.sv
hdl/rtex_if.sv
hdl/rtex_ram.sv
hdl/rtex_div.sv
hdl/r_type_instruction_execute_unit.sv
hdl/rtex_checker.sv
dv/tb_r_type_instruction_execute_unit.sv
